FILE: rtl/cfp_pkg.sv
`default_nettype none

package cfp_pkg;

  localparam int unsigned MaxElements     = 8;
  localparam int unsigned MaxElementBytes = 255;

  localparam int unsigned DescWidth  = 16;
  localparam int unsigned CfgWidth   = 64;
  localparam int unsigned CountWidth = 4;
  localparam int unsigned OutWidth   = 24;

  localparam logic [7:0] ByteMax = 8'hff;

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_MAGIC    = 2'd1,
    KIND_LENGTH   = 2'd2,
    KIND_CHECKSUM = 2'd3
  } elem_kind_e;

  typedef enum logic [2:0] {
    ST_ACCEPTED    = 3'd0,
    ST_COMPLETE    = 3'd1,
    ST_MAGIC_FAIL  = 3'd2,
    ST_CHKSUM_FAIL = 3'd3,
    ST_IGNORED     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CFG_DESC_LOW  = 2'd0,
    CFG_DESC_HIGH = 2'd1,
    CFG_COUNT     = 2'd2,
    CFG_MAGIC     = 2'd3
  } cfg_index_e;

  // Descriptor i sits in the low register for elements 0..3, in the high one otherwise.
  function automatic logic [DescWidth-1:0] desc_of(input logic [CfgWidth-1:0] lo,
                                                   input logic [CfgWidth-1:0] hi,
                                                   input logic [2:0]          idx);
    logic [CfgWidth-1:0] word;
    word = idx[2] ? hi : lo;
    return word[{idx[1:0], 4'b0000} +: DescWidth];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/configurable_frame_parser.sv
`default_nettype none

// Frame parser for a byte stream laid out by up to eight element descriptors
// (data, magic, length, checksum). Every received byte produces exactly one
// result transfer carrying the byte, the element and offset it was matched
// against, and a status (accepted, frame complete, magic fail, checksum fail,
// ignored). The block takes one byte per clock cycle while the output is ready;
// the result is registered, and the element pointer, offset, running sum and field value are all updated by
// a single registered step. The result register takes a new byte in the same
// cycle in which its previous result is taken, so bytes stream back to back
// while the output is ready; a result that still waits holds off the input.
// Any configuration write restarts the parser; there is no initialization
// pass after reset.
module configurable_frame_parser #(
  parameter int unsigned MAX_ELEMENTS      = cfp_pkg::MaxElements,
  parameter int unsigned MAX_ELEMENT_BYTES = cfp_pkg::MaxElementBytes
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,

  input  wire logic                         cfg_we_i,
  input  wire logic [1:0]                   cfg_index_i,
  input  wire logic [cfp_pkg::CfgWidth-1:0] cfg_data_i,

  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [7:0]                   s_axis_tdata,   // rx_byte

  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // data_byte[7:0], element_number[10:8], byte_offset[18:11], status[21:19], zero[23:22]
  output logic [cfp_pkg::OutWidth-1:0]      m_axis_tdata
);

  localparam logic [cfp_pkg::CountWidth-1:0] NumMax =
    cfp_pkg::CountWidth'(MAX_ELEMENTS);
  localparam logic [7:0] SizeMax = 8'(MAX_ELEMENT_BYTES);

  // Configuration registers
  logic [cfp_pkg::CfgWidth-1:0]   desc_lo_q, desc_hi_q, magic_q;
  logic [cfp_pkg::CountWidth-1:0] count_q;

  // Parser state; restart_q stands for the freshly restarted state.
  logic                 restart_q;
  logic [2:0]           ptr_q;
  logic [7:0]           off_q, size_q, bound_q;
  logic                 acc_q, seen_q;
  logic [63:0]          sum_q, val_q;

  logic                        out_valid_q;
  logic [cfp_pkg::OutWidth-1:0] out_data_q;

  logic s_fire;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  function automatic logic [7:0] elem_size(input logic [cfp_pkg::DescWidth-1:0] d,
                                           input logic                         seen,
                                           input logic [7:0]                   bound);
    logic [7:0] s;
    s = (d[7:0] > SizeMax) ? SizeMax : d[7:0];
    if (d[12] && seen && (bound < s)) begin
      s = bound;
    end
    return s;
  endfunction

  logic [cfp_pkg::CountWidth-1:0] n_used;
  logic [7:0] first_sz [MAX_ELEMENTS];
  logic [7:0] next_sz  [MAX_ELEMENTS];
  logic       first_found, next_found;
  logic [2:0] first_idx, next_idx;
  logic [7:0] first_size, next_size;

  logic [2:0]  ptr_e;
  logic [7:0]  off_e, size_e, bound_e;
  logic        acc_e, seen_e, active_e;
  logic [63:0] sum_e, val_e;

  logic [cfp_pkg::DescWidth-1:0] desc;
  cfp_pkg::elem_kind_e            kind;
  logic                           rev, sumf, last;
  logic [7:0]                     mag_idx, expect_b, b;
  logic                           magic_bad, ck_bad;
  logic [63:0]                    new_sum, new_val, mask;
  logic                           len_hit, seen_n;
  logic [7:0]                     bound_n;
  logic [cfp_pkg::CountWidth-1:0] next_start;
  cfp_pkg::status_e               status;

  assign n_used = (count_q > NumMax) ? NumMax : count_q;
  assign b      = s_axis_tdata;

  // First nonempty element of a fresh frame.
  always_comb begin
    first_found = 1'b0;
    first_idx   = '0;
    first_size  = '0;
    for (int i = MAX_ELEMENTS - 1; i >= 0; i--) begin
      first_sz[i] = elem_size(cfp_pkg::desc_of(desc_lo_q, desc_hi_q, 3'(i)), 1'b0, 8'd0);
      if ((cfp_pkg::CountWidth'(i) < n_used) && (first_sz[i] != 8'd0)) begin
        first_found = 1'b1;
        first_idx   = 3'(i);
        first_size  = first_sz[i];
      end
    end
  end

  // Effective state: a pending restart overrides the stored state.
  always_comb begin
    if (restart_q) begin
      ptr_e    = first_found ? first_idx : 3'd0;
      off_e    = '0;
      size_e   = first_size;
      acc_e    = 1'b0;
      seen_e   = 1'b0;
      bound_e  = '0;
      sum_e    = '0;
      val_e    = '0;
      active_e = first_found;
    end else begin
      ptr_e    = ptr_q;
      off_e    = off_q;
      size_e   = size_q;
      acc_e    = acc_q;
      seen_e   = seen_q;
      bound_e  = bound_q;
      sum_e    = sum_q;
      val_e    = val_q;
      active_e = 1'b1;
    end
  end

  always_comb begin
    desc = cfp_pkg::desc_of(desc_lo_q, desc_hi_q, ptr_e);
    kind = cfp_pkg::elem_kind_e'(desc[9:8]);
    rev  = desc[10];
    sumf = desc[11];
    last = ({1'b0, off_e} + 9'd1) == {1'b0, size_e};

    mag_idx   = rev ? (size_e - 8'd1 - off_e) : off_e;
    expect_b  = (mag_idx < 8'd8) ? magic_q[{mag_idx[2:0], 3'b000} +: 8] : 8'd0;
    magic_bad = (kind == cfp_pkg::KIND_MAGIC) && (expect_b != b);

    new_sum = sumf ? (sum_e + {56'd0, b}) : sum_e;
    if (rev) begin
      new_val = {val_e[55:0], b};
    end else if (off_e < 8'd8) begin
      new_val = val_e | ({56'd0, b} << {off_e[2:0], 3'b000});
    end else begin
      new_val = val_e;
    end

    mask   = (size_e >= 8'd8) ? '1 : ~('1 << {size_e[2:0], 3'b000});
    ck_bad = !magic_bad && last && (kind == cfp_pkg::KIND_CHECKSUM) &&
             (new_val != (new_sum & mask));

    // Only the first length element after element zero binds sizes.
    len_hit = last && (kind == cfp_pkg::KIND_LENGTH) && (ptr_e != 3'd0) && !seen_e;
    seen_n  = seen_e || len_hit;
    bound_n = len_hit ? ((|new_val[63:8]) ? cfp_pkg::ByteMax : new_val[7:0]) : bound_e;
  end

  // Next nonempty element after the current one, with any fresh length binding.
  always_comb begin
    next_start = {1'b0, ptr_e} + cfp_pkg::CountWidth'(1);
    next_found = 1'b0;
    next_idx   = '0;
    next_size  = '0;
    for (int i = MAX_ELEMENTS - 1; i >= 0; i--) begin
      next_sz[i] = elem_size(cfp_pkg::desc_of(desc_lo_q, desc_hi_q, 3'(i)), seen_n, bound_n);
      if ((cfp_pkg::CountWidth'(i) >= next_start) &&
          (cfp_pkg::CountWidth'(i) < n_used) && (next_sz[i] != 8'd0)) begin
        next_found = 1'b1;
        next_idx   = 3'(i);
        next_size  = next_sz[i];
      end
    end
  end

  always_comb begin
    priority if (!active_e) begin
      status = cfp_pkg::ST_IGNORED;
    end else if (magic_bad) begin
      status = acc_e ? cfp_pkg::ST_MAGIC_FAIL : cfp_pkg::ST_IGNORED;
    end else if (ck_bad) begin
      status = acc_e ? cfp_pkg::ST_CHKSUM_FAIL : cfp_pkg::ST_IGNORED;
    end else if (last && !next_found) begin
      status = cfp_pkg::ST_COMPLETE;
    end else begin
      status = cfp_pkg::ST_ACCEPTED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_lo_q <= '0;
      desc_hi_q <= '0;
      count_q   <= cfp_pkg::CountWidth'(1);
      magic_q   <= '0;
      restart_q <= 1'b1;
      ptr_q     <= '0;
      off_q     <= '0;
      size_q    <= '0;
      acc_q     <= 1'b0;
      seen_q    <= 1'b0;
      bound_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfp_pkg::cfg_index_e'(cfg_index_i))
        cfp_pkg::CFG_DESC_LOW:  desc_lo_q <= cfg_data_i;
        cfp_pkg::CFG_DESC_HIGH: desc_hi_q <= cfg_data_i;
        cfp_pkg::CFG_COUNT:     count_q   <= cfg_data_i[cfp_pkg::CountWidth-1:0];
        cfp_pkg::CFG_MAGIC:     magic_q   <= cfg_data_i;
        default:                count_q   <= count_q;
      endcase
      restart_q <= 1'b1;
    end else if (s_fire) begin
      unique case (status)
        cfp_pkg::ST_MAGIC_FAIL, cfp_pkg::ST_CHKSUM_FAIL, cfp_pkg::ST_COMPLETE: begin
          restart_q <= 1'b1;
        end
        cfp_pkg::ST_ACCEPTED: begin
          restart_q <= 1'b0;
          acc_q     <= 1'b1;
          seen_q    <= seen_n;
          bound_q   <= bound_n;
          if (last) begin
            ptr_q  <= next_idx;
            size_q <= next_size;
            off_q  <= '0;
          end else begin
            ptr_q  <= ptr_e;
            size_q <= size_e;
            off_q  <= off_e + 8'd1;
          end
        end
        default: begin
          restart_q <= restart_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire && !cfg_we_i && (status == cfp_pkg::ST_ACCEPTED)) begin
      sum_q <= new_sum;
      val_q <= last ? 64'd0 : new_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      out_data_q <= {2'b00, status, off_e, ptr_e, b};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Every configuration write leaves the parser at the start of a frame.
  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> restart_q)
    else $error("configuration write did not restart the parser");

  // A completed frame always starts over.
  a_complete_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && !cfg_we_i && (status == cfp_pkg::ST_COMPLETE)) |=> restart_q)
    else $error("parser did not restart after a complete frame");

  // Inside a frame the current element is nonempty and the offset lies within it.
  a_offset_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !restart_q |-> ((size_q != 8'd0) && (off_q < size_q)))
    else $error("element offset outside the current element");

  // An ignored byte never advances the parser.
  a_ignored_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && !cfg_we_i && (status == cfp_pkg::ST_IGNORED)) |=>
      ($stable(restart_q) && $stable(ptr_q) && $stable(off_q)))
    else $error("ignored byte changed the parser state");

endmodule

`default_nettype wire
